### rtl/assert_macros.svh
// assertion macros for the rtl files, included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ON(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) `ASSERT_ON(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_ON(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/hbk_pkg.sv
`timescale 1ns / 1ps

package hbk_pkg;

	localparam int KEY_SLOTS   = 6;
	localparam int SLOT_FIELDS = 6;
	localparam int EVENTS      = 2 * KEY_SLOTS;

	typedef logic [7:0] key_t;
	typedef logic [EVENTS-1:0] evt_mask_t;

	// press candidates in the low half, release candidates in the high half
	typedef struct packed {
		evt_mask_t              mask;
		key_t [EVENTS-1:0]      keys;
		logic [7:0]             mods;
	} hbk_diff_t;

endpackage

### rtl/hbk_diff.sv
`timescale 1ns / 1ps

module hbk_diff (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    req_valid,
	output logic                                    req_ready,
	input  logic                                    transfer_ok,
	input  logic [7:0]                              modifiers,
	input  hbk_pkg::key_t [hbk_pkg::KEY_SLOTS-1:0]  slots,
	output logic                                    diff_valid,
	output hbk_pkg::hbk_diff_t                      diff,
	input  logic                                    diff_take
);
	import hbk_pkg::*;

	logic                        valid_s1;
	logic [7:0]                  mods_s1;
	key_t [KEY_SLOTS-1:0]        keys_s1;
	key_t [KEY_SLOTS-1:0]        prev_q;

	function automatic logic holds(input key_t [KEY_SLOTS-1:0] s, input key_t k);
		logic hit;
		hit = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (s[j] == k)
				hit = 1'b1;
		end
		return hit;
	endfunction

	assign req_ready  = !valid_s1 || diff_take;
	assign diff_valid = valid_s1;

	// failed transfers are taken and dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prev_q   <= '0;
		end else begin
			if (req_ready)
				valid_s1 <= req_valid && transfer_ok;
			if (diff_take)
				prev_q <= keys_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			keys_s1 <= slots;
			mods_s1 <= modifiers;
		end
	end

	always_comb begin
		diff.mods = mods_s1;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			diff.keys[i]             = keys_s1[i];
			diff.keys[KEY_SLOTS + i] = prev_q[i];
			diff.mask[i]             = (keys_s1[i] != '0) && !holds(prev_q, keys_s1[i]);
			diff.mask[KEY_SLOTS + i] = (prev_q[i] != '0) && !holds(keys_s1, prev_q[i]);
		end
	end

endmodule

### rtl/hbk_emit.sv
`timescale 1ns / 1ps

module hbk_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                diff_valid,
	input  hbk_pkg::hbk_diff_t  diff,
	output logic                load_ok,
	output logic                evt_valid,
	input  logic                evt_ready,
	output logic [7:0]          key_usage,
	output logic                released,
	output logic [7:0]          event_modifiers,
	output logic                last_event
);
	import hbk_pkg::*;

	evt_mask_t          mask_q;
	key_t [EVENTS-1:0]  keys_q;
	logic [7:0]         mods_q;
	logic               valid_q;
	key_t               key_q;
	logic               rel_q;
	logic [7:0]         emods_q;
	logic               last_q;

	evt_mask_t          pick;
	evt_mask_t          rest;
	key_t               sel_key;
	logic               out_free;
	logic               pop;
	logic               load;

	// lowest pending event goes first: presses, then releases, in slot order
	assign pick     = mask_q & (~mask_q + 1'b1);
	assign rest     = mask_q & ~pick;
	assign out_free = !valid_q || evt_ready;
	assign pop      = out_free && (mask_q != '0);
	assign load_ok  = (mask_q == '0) || (pop && (rest == '0));
	assign load     = diff_valid && load_ok;

	always_comb begin
		sel_key = '0;
		for (int i = 0; i < EVENTS; i++) begin
			if (pick[i])
				sel_key = sel_key | keys_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load)
				mask_q <= diff.mask;
			else if (pop)
				mask_q <= rest;
			if (out_free)
				valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			keys_q <= diff.keys;
			mods_q <= diff.mods;
		end
		if (pop) begin
			key_q   <= sel_key;
			rel_q   <= |pick[EVENTS-1:KEY_SLOTS];
			emods_q <= mods_q;
			last_q  <= (rest == '0);
		end
	end

	assign evt_valid       = valid_q;
	assign key_usage       = key_q;
	assign released        = rel_q;
	assign event_modifiers = emods_q;
	assign last_event      = last_q;

endmodule

### rtl/hid_boot_keyboard_key_diff_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Boot-keyboard report differencer. Each request is one report; good reports
// produce press events for new keys, then release events for keys that
// disappeared, one event per cycle while evt_ready holds, with last_event on
// the final one. Failed reports are accepted and dropped. A report is
// registered, compared against the stored slots in the next cycle, loaded
// into the event buffer and then moved to the output register as events.
// The event buffer drains one event a cycle while evt_ready is high, which
// sets the sustained rate; a report yields at most 12 events.
// The next report is already taken and compared while the buffer drains.

module hid_boot_keyboard_key_diff_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        transfer_ok,
	input  logic [7:0]  modifiers,
	input  logic [7:0]  key_slot_0,
	input  logic [7:0]  key_slot_1,
	input  logic [7:0]  key_slot_2,
	input  logic [7:0]  key_slot_3,
	input  logic [7:0]  key_slot_4,
	input  logic [7:0]  key_slot_5,
	output logic        evt_valid,
	input  logic        evt_ready,
	output logic [7:0]  key_usage,
	output logic        released,
	output logic [7:0]  event_modifiers,
	output logic        last_event
);
	import hbk_pkg::*;

	key_t [SLOT_FIELDS-1:0] report_keys;
	key_t [KEY_SLOTS-1:0]   slots;
	logic                   diff_valid;
	hbk_diff_t              diff;
	logic                   load_ok;
	logic                   diff_take;

	assign report_keys = {key_slot_5, key_slot_4, key_slot_3,
		key_slot_2, key_slot_1, key_slot_0};

	// slots past the report read as empty
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
		if (g < SLOT_FIELDS) begin : g_used
			assign slots[g] = report_keys[g];
		end else begin : g_empty
			assign slots[g] = '0;
		end
	end

	assign diff_take = diff_valid && load_ok;

	hbk_diff u_diff (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.transfer_ok (transfer_ok),
		.modifiers   (modifiers),
		.slots       (slots),
		.diff_valid  (diff_valid),
		.diff        (diff),
		.diff_take   (diff_take)
	);

	hbk_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.diff_valid      (diff_valid),
		.diff            (diff),
		.load_ok         (load_ok),
		.evt_valid       (evt_valid),
		.evt_ready       (evt_ready),
		.key_usage       (key_usage),
		.released        (released),
		.event_modifiers (event_modifiers),
		.last_event      (last_event)
	);

	`ASSERT_NEVER(a_key_nonzero, clk, arst_n, evt_valid && (key_usage == '0))
	`ASSERT_ON(a_fail_dropped, clk, arst_n, (req_valid && req_ready && !transfer_ok) |=> !diff_valid)
	`ASSERT_ON(a_burst_cont, clk, arst_n, (evt_valid && evt_ready && !last_event) |=> evt_valid)

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import hbk_pkg::*;

	typedef struct packed {
		logic            ok;
		logic [7:0]      mods;
		logic [5:0][7:0] slot;
	} report_t;

	typedef struct packed {
		key_t       key;
		logic       rel;
		logic [7:0] mods;
		logic       last;
	} key_event_t;

	localparam int GOOD_REPORTS = 410;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	logic       transfer_ok = 1'b0;
	logic [7:0] modifiers = 8'h00;
	logic [7:0] key_slot_0 = 8'h00;
	logic [7:0] key_slot_1 = 8'h00;
	logic [7:0] key_slot_2 = 8'h00;
	logic [7:0] key_slot_3 = 8'h00;
	logic [7:0] key_slot_4 = 8'h00;
	logic [7:0] key_slot_5 = 8'h00;
	logic       evt_valid;
	logic       evt_ready = 1'b0;
	logic [7:0] key_usage;
	logic       released;
	logic [7:0] event_modifiers;
	logic       last_event;

	report_t    queued_reports[$];
	report_t    cur_report;
	key_event_t pending_events[$];
	logic [KEY_SLOTS-1:0][7:0] held_keys = '0;

	int cycle_count = 0;
	int error_count = 0;
	int reports_taken = 0;
	int good_taken = 0;
	int events_checked = 0;
	int releases_checked = 0;

	hid_boot_keyboard_key_diff_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.transfer_ok     (transfer_ok),
		.modifiers       (modifiers),
		.key_slot_0      (key_slot_0),
		.key_slot_1      (key_slot_1),
		.key_slot_2      (key_slot_2),
		.key_slot_3      (key_slot_3),
		.key_slot_4      (key_slot_4),
		.key_slot_5      (key_slot_5),
		.evt_valid       (evt_valid),
		.evt_ready       (evt_ready),
		.key_usage       (key_usage),
		.released        (released),
		.event_modifiers (event_modifiers),
		.last_event      (last_event)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// calm window with no idling on either side
	function automatic bit take_break();
		if (cycle_count >= 1500 && cycle_count < 3500)
			return 1'b0;
		return $urandom_range(0, 99) < 33;
	endfunction

	function automatic bit slot_has(input logic [KEY_SLOTS-1:0][7:0] set, input key_t k);
		for (int i = 0; i < KEY_SLOTS; i++)
			if (set[i] == k)
				return 1'b1;
		return 1'b0;
	endfunction

	// presses in new slot order, then releases in stored slot order
	task automatic diff_report(input report_t r);
		logic [KEY_SLOTS-1:0][7:0] fresh;
		key_event_t batch[$];
		key_event_t e;
		begin
			if (r.ok) begin
				for (int i = 0; i < KEY_SLOTS; i++)
					fresh[i] = (i < SLOT_FIELDS) ? r.slot[i] : 8'h00;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					if (fresh[i] != 8'h00 && !slot_has(held_keys, fresh[i])) begin
						e = '{key: fresh[i], rel: 1'b0, mods: r.mods, last: 1'b0};
						batch.push_back(e);
					end
				end
				for (int i = 0; i < KEY_SLOTS; i++) begin
					if (held_keys[i] != 8'h00 && !slot_has(fresh, held_keys[i])) begin
						e = '{key: held_keys[i], rel: 1'b1, mods: r.mods, last: 1'b0};
						batch.push_back(e);
					end
				end
				for (int i = 0; i < batch.size(); i++) begin
					e = batch[i];
					e.last = (i == batch.size() - 1);
					pending_events.push_back(e);
				end
				held_keys = fresh;
				good_taken++;
			end
		end
	endtask

	task automatic flag_error(input string msg);
		begin
			if (error_count < 10)
				$display("%0t: %s", $realtime, msg);
			error_count++;
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				diff_report(cur_report);
				reports_taken++;
			end
			if (!req_valid || req_ready) begin
				if (queued_reports.size() > 0 && !take_break()) begin
					cur_report = queued_reports.pop_front();
					req_valid   <= 1'b1;
					transfer_ok <= cur_report.ok;
					modifiers   <= cur_report.mods;
					key_slot_0  <= cur_report.slot[0];
					key_slot_1  <= cur_report.slot[1];
					key_slot_2  <= cur_report.slot[2];
					key_slot_3  <= cur_report.slot[3];
					key_slot_4  <= cur_report.slot[4];
					key_slot_5  <= cur_report.slot[5];
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// event monitor
	always @(posedge clk) begin
		key_event_t want;
		if (!arst_n) begin
			evt_ready <= 1'b0;
		end else begin
			if (evt_valid && evt_ready) begin
				if (pending_events.size() == 0) begin
					flag_error($sformatf("unexpected event key %02h rel %0b mods %02h last %0b",
						key_usage, released, event_modifiers, last_event));
				end else begin
					want = pending_events.pop_front();
					if (key_usage !== want.key || released !== want.rel ||
							event_modifiers !== want.mods || last_event !== want.last)
						flag_error($sformatf(
							"event mismatch: expected key %02h rel %0b mods %02h last %0b, got key %02h rel %0b mods %02h last %0b",
							want.key, want.rel, want.mods, want.last,
							key_usage, released, event_modifiers, last_event));
					events_checked++;
					if (want.rel)
						releases_checked++;
				end
			end
			evt_ready <= !take_break();
		end
	end

	task automatic add_report(input logic ok, input logic [7:0] mods,
			input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
			input logic [7:0] s3, input logic [7:0] s4, input logic [7:0] s5);
		report_t r;
		begin
			r.ok = ok;
			r.mods = mods;
			r.slot = {s5, s4, s3, s2, s1, s0};
			queued_reports.push_back(r);
		end
	endtask

	initial begin
		report_t r;
		logic [5:0][7:0] last_slots;
		int good_made;
		int pick;
		// directed part
		add_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_report(1'b0, 8'h33, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
		add_report(1'b1, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_report(1'b1, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
		add_report(1'b1, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
		add_report(1'b1, 8'h55, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
		add_report(1'b0, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_report(1'b1, 8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h01, 8'h00);
		add_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_report(1'b1, 8'h01, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F);
		add_report(1'b1, 8'h80, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15);
		add_report(1'b1, 8'h7F, 8'h15, 8'h14, 8'h13, 8'h12, 8'h11, 8'h10);
		add_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00);
		add_report(1'b1, 8'hFE, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04);
		add_report(1'b1, 8'h00, 8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB);
		add_report(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		add_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_report(1'b1, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h03);
		add_report(1'b1, 8'h10, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

		// random part: mostly reports evolved from the last good one
		last_slots = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03};
		good_made = 0;
		while (good_made < GOOD_REPORTS) begin
			r.ok = ($urandom_range(0, 99) < 85);
			r.mods = 8'($urandom);
			if ($urandom_range(0, 99) < 25) begin
				for (int i = 0; i < 6; i++)
					r.slot[i] = 8'($urandom);
			end else begin
				for (int i = 0; i < 6; i++) begin
					pick = $urandom_range(0, 9);
					case (pick)
						0, 1, 2, 3, 4: r.slot[i] = last_slots[i];
						5: r.slot[i] = 8'h00;
						6: r.slot[i] = last_slots[$urandom_range(0, 5)];
						7: r.slot[i] = 8'($urandom_range(1, 255));
						8: r.slot[i] = 8'($urandom_range(4, 11));
						default: r.slot[i] = (i > 0) ? r.slot[$urandom_range(0, i - 1)] : 8'h00;
					endcase
				end
			end
			queued_reports.push_back(r);
			if (r.ok) begin
				last_slots = r.slot;
				good_made++;
			end
		end

		while (queued_reports.size() > 0 || req_valid)
			@(posedge clk);
		while (pending_events.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d reports (%0d good), checked %0d events, %0d of them releases",
			reports_taken, good_taken, events_checked, releases_checked);
		$display("mismatches and stray events: %0d", error_count);
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("timeout after %0d cycles, %0d events still due", cycle_count,
			pending_events.size());
		$display("testbench: done, errors");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/hbk_pkg.sv
rtl/hbk_diff.sv
rtl/hbk_emit.sv
rtl/hid_boot_keyboard_key_diff_unit.sv
dv/testbench.sv
